[src/ssd_pkg.sv]
package ssd_pkg;

  localparam int STRING_DEPTH = 32;
  localparam int DIGIT_COUNT  = 4;  // banks follow digits: must be a power of two

  localparam int DIGIT_BITS = $clog2(DIGIT_COUNT);
  localparam int BANK_DEPTH = STRING_DEPTH / DIGIT_COUNT;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int LEN_W      = $clog2(STRING_DEPTH + 1);
  localparam int POS_W      = 8;
  localparam int IDX_W      = POS_W + 1;
  localparam int POINT_W    = 7;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_MUX     = 2'd1;
  localparam logic [1:0] CMD_SHIFT   = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic signed [POINT_W-1:0] POINT_NONE = -7'sd5;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [7:0] TABLE_FIRST = 8'h2D;
  localparam int         TABLE_SIZE  = 52;
  localparam logic [7:0] TABLE_END   = 8'(TABLE_FIRST + TABLE_SIZE);
  localparam logic [7:0] DP_BIT      = 8'h80;

  // segments A..G in bits 6..0; entries run from '-' to '`'
  localparam logic [6:0] GLYPHS [TABLE_SIZE] = '{
    7'h01, 7'h00, 7'h00,
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h77, 7'h7C, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06,
    7'h3C, 7'h57, 7'h0E, 7'h6A, 7'h15, 7'h7E, 7'h67, 7'h73, 7'h05,
    7'h5B, 7'h0F, 7'h3E, 7'h2A, 7'h7F, 7'h49, 7'h3B, 7'h6D,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00
  };

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } ssd_wr_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } ssd_rd_t;

  function automatic logic [6:0] glyph(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] off;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    off = u - TABLE_FIRST;
    if (u < TABLE_FIRST || u >= TABLE_END) begin
      return '0;
    end
    return GLYPHS[off[5:0]];
  endfunction

endpackage

[src/ssd_ram.sv]
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ssd_window.sv]
// Text store split into one bank per digit, so a window of consecutive
// characters hits every bank once. Read data holds until the next shift.
module ssd_window (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ssd_pkg::ssd_wr_t                            wr,
  input  ssd_pkg::ssd_rd_t                            rd,
  output logic [ssd_pkg::DIGIT_COUNT-1:0][7:0]        win_chars
);
  import ssd_pkg::*;

  logic [DIGIT_COUNT-1:0][7:0]  bank_data;
  logic [DIGIT_COUNT-1:0]       in_range;
  logic [DIGIT_COUNT-1:0]       in_range_next;
  logic [DIGIT_BITS-1:0]        base;

  for (genvar b = 0; b < DIGIT_COUNT; b++) begin : g_bank
    logic [DIGIT_BITS-1:0] offset;
    logic [IDX_W-1:0]      ridx;
    logic                  bank_we;

    assign offset  = DIGIT_BITS'(b) - rd.pos[DIGIT_BITS-1:0];
    assign ridx    = {1'b0, rd.pos} + IDX_W'(offset);
    assign bank_we = wr.en && (wr.idx[DIGIT_BITS-1:0] == DIGIT_BITS'(b));

    ssd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (wr.idx[DIGIT_BITS +: BANK_AW]),
      .wdata (wr.data),
      .re    (rd.en),
      .raddr (ridx[DIGIT_BITS +: BANK_AW]),
      .rdata (bank_data[b])
    );
  end

  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      in_range_next[d] = ({1'b0, rd.pos} + IDX_W'(d)) < IDX_W'(rd.len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_range <= '0;
    end else if (rd.en) begin
      in_range <= in_range_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      base <= rd.pos[DIGIT_BITS-1:0];
    end
  end

  // places past the end of the text read as zero, which shows blank
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      win_chars[d] = in_range[d] ? bank_data[DIGIT_BITS'(base + DIGIT_BITS'(d))] : 8'h00;
    end
  end

endmodule

[src/scrolling_seven_segment_driver.sv]
// Scrolling seven-segment driver for a four-digit multiplexed display.
//
// Input channel (in_valid/in_ready) carries one word per command: cmd,
// char_code and last_char. Load words build the text one character at a
// time; the first '.' of a string becomes a decimal point on the character
// before it. Multiplex ticks step the lit digit, shift ticks move the window
// and bounce it at the ends, restart sets position 1 scrolling right to left.
//
// Output channel (out_valid/out_ready) returns one word per input word: the
// drive pattern (digit_enable, segments) as it stands after that command.
//
// An accepted word passes through the input register, then the result
// register. Throughput: one word per cycle while the receiver takes words,
// set by the single state update between the two registers; the banked text
// store gives every digit its own read port, so a window reload does not stall.
// A stalled receiver holds the result word; one more word waits in the input
// register, then in_ready drops. Reset (rst, synchronous) empties both
// registers, blanks the window, sets the text length to zero and turns all digits off.
module scrolling_seven_segment_driver (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] digit_enable,
  output logic [7:0] segments
);
  import ssd_pkg::*;

  // input register
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       advance;

  // block state
  logic [LEN_W-1:0]          text_length, text_length_next;
  logic [LEN_W-1:0]          load_index, load_index_next;
  logic                      dot_seen, dot_seen_next;
  logic signed [POINT_W-1:0] point_position, point_position_next;
  logic [POS_W-1:0]          scroll_position, scroll_position_next;
  logic                      scroll_direction, scroll_direction_next;
  logic [DIGIT_BITS-1:0]     active_digit, active_digit_next;
  logic [3:0]                drive_enable, drive_enable_next;
  logic [7:0]                drive_segments, drive_segments_next;

  ssd_wr_t                     wr;
  ssd_rd_t                     rd;
  logic [DIGIT_COUNT-1:0][7:0] win_chars;

  // scratch for shift and multiplex
  logic [POS_W-1:0]        moved_pos;
  logic signed [IDX_W-1:0] turn_limit;
  logic [IDX_W+0:0]        shown_index;
  logic [7:0]              seg_mux;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= cmd;
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  ssd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd        (rd),
    .win_chars (win_chars)
  );

  // shift: move, then turn round at the ends (signed compare against
  // length minus digit count, which goes negative for short text)
  assign moved_pos  = scroll_direction ? scroll_position - 1'b1 : scroll_position + 1'b1;
  assign turn_limit = $signed(IDX_W'(text_length)) - $signed(IDX_W'(DIGIT_COUNT));

  // point lights when its index equals position plus digit; a point at -1
  // or none never matches since the sum stays non-negative
  assign shown_index = (IDX_W + 1)'(scroll_position) + (IDX_W + 1)'(active_digit);

  always_comb begin
    seg_mux = {1'b0, glyph(win_chars[active_digit])};
    if ((IDX_W + 1)'(point_position) == shown_index) begin
      seg_mux = seg_mux | DP_BIT;
    end
  end

  always_comb begin
    text_length_next      = text_length;
    load_index_next       = load_index;
    dot_seen_next         = dot_seen;
    point_position_next   = point_position;
    scroll_position_next  = scroll_position;
    scroll_direction_next = scroll_direction;
    active_digit_next     = active_digit;
    drive_enable_next     = drive_enable;
    drive_segments_next   = drive_segments;
    wr                    = '{en: 1'b0, idx: load_index, data: s1_char};
    rd                    = '{en: 1'b0, pos: moved_pos, len: text_length};

    if (advance) begin
      unique case (s1_cmd)
        CMD_LOAD: begin
          if (load_index == '0 && !dot_seen) begin
            point_position_next = POINT_NONE;
          end
          if (s1_char == DOT_CHAR && !dot_seen) begin
            dot_seen_next       = 1'b1;
            point_position_next = $signed(POINT_W'(load_index)) - 7'sd1;
          end else if (load_index < LEN_W'(STRING_DEPTH)) begin
            wr.en           = 1'b1;
            load_index_next = load_index + 1'b1;
          end
          if (s1_last) begin
            text_length_next = load_index_next;
            load_index_next  = '0;
            dot_seen_next    = 1'b0;
          end
        end
        CMD_MUX: begin
          drive_segments_next = seg_mux;
          drive_enable_next   = 4'(1 << active_digit);
          active_digit_next   = active_digit + 1'b1;
        end
        CMD_SHIFT: begin
          scroll_position_next = moved_pos;
          if ($signed({1'b0, moved_pos}) >= turn_limit) begin
            scroll_direction_next = 1'b1;
          end
          if (moved_pos == '0) begin
            scroll_direction_next = 1'b0;
          end
          rd.en = 1'b1;
        end
        CMD_RESTART: begin
          scroll_position_next  = POS_W'(1);
          scroll_direction_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length      <= '0;
      load_index       <= '0;
      dot_seen         <= 1'b0;
      point_position   <= POINT_NONE;
      scroll_position  <= '0;
      scroll_direction <= 1'b0;
      active_digit     <= '0;
      drive_enable     <= '0;
      drive_segments   <= '0;
    end else begin
      text_length      <= text_length_next;
      load_index       <= load_index_next;
      dot_seen         <= dot_seen_next;
      point_position   <= point_position_next;
      scroll_position  <= scroll_position_next;
      scroll_direction <= scroll_direction_next;
      active_digit     <= active_digit_next;
      drive_enable     <= drive_enable_next;
      drive_segments   <= drive_segments_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      digit_enable <= drive_enable_next;
      segments     <= drive_segments_next;
    end
  end

endmodule

[src/ssd_checker.sv]
module ssd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] digit_enable,
  input logic [7:0] segments
);

  // at most one digit driven at a time
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(digit_enable))
    else $error("more than one digit enabled");

  // lit segments only after a multiplex tick has picked a digit
  a_seg_needs_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && segments != 8'h00) |-> digit_enable != 4'h0)
    else $error("segments lit with no digit enabled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(digit_enable) && $stable(segments)))
    else $error("stalled output word changed");

endmodule

bind scrolling_seven_segment_driver ssd_checker u_ssd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .digit_enable (digit_enable),
  .segments     (segments)
);

[bench/tb_scrolling_seven_segment_driver.sv]
module tb_scrolling_seven_segment_driver;
  import ssd_pkg::*;

  localparam int NO_POINT    = -5;      // point register value meaning "no point"
  localparam int WORD_TARGET = 475;     // directed part plus about 450 random words
  localparam int LONG_HOLD   = 80;      // receiver hold-off, enough to back up the input
  localparam int DRAIN_WAIT  = 10;      // input and result registers, plenty of margin
  localparam int CYCLE_LIMIT = 300000;  // watchdog limit, far above the worst case

  // one expected drive pattern
  typedef struct packed {
    logic [3:0] en;
    logic [7:0] seg;
  } drive_t;

  // Predicts the held drive pattern after every accepted command word and
  // checks the returned words against it in order.
  class display_scoreboard;
    logic [7:0] text_mem [STRING_DEPTH];
    logic [7:0] window   [DIGIT_COUNT];
    int         text_len;
    int         load_idx;
    int         point_pos;
    int         digit_sel;
    bit         dot_seen;
    bit         scroll_left;   // 1: position counts down
    logic [7:0] scroll_pos;
    logic [3:0] drive_en;
    logic [7:0] drive_seg;
    drive_t     drive_q [$];
    int         mismatches;

    function new();
      foreach (text_mem[i]) text_mem[i] = 8'h00;
      foreach (window[i]) window[i] = 8'h20;
      text_len    = 0;
      load_idx    = 0;
      point_pos   = NO_POINT;
      digit_sel   = 0;
      dot_seen    = 1'b0;
      scroll_left = 1'b0;
      scroll_pos  = 8'h00;
      drive_en    = 4'h0;
      drive_seg   = 8'h00;
      mismatches  = 0;
    endfunction

    // segments A..G for one character; lower case folds to upper
    function logic [6:0] seg_of(input logic [7:0] c);
      logic [7:0] u;
      u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
      case (u)
        "-": return 7'h01;
        "0": return 7'h7E;
        "1": return 7'h30;
        "2": return 7'h6D;
        "3": return 7'h79;
        "4": return 7'h33;
        "5": return 7'h5B;
        "6": return 7'h5F;
        "7": return 7'h70;
        "8": return 7'h7F;
        "9": return 7'h7B;
        "A": return 7'h77;
        "B": return 7'h7C;
        "C": return 7'h4E;
        "D": return 7'h3D;
        "E": return 7'h4F;
        "F": return 7'h47;
        "G": return 7'h5E;
        "H": return 7'h37;
        "I": return 7'h06;
        "J": return 7'h3C;
        "K": return 7'h57;
        "L": return 7'h0E;
        "M": return 7'h6A;
        "N": return 7'h15;
        "O": return 7'h7E;
        "P": return 7'h67;
        "Q": return 7'h73;
        "R": return 7'h05;
        "S": return 7'h5B;
        "T": return 7'h0F;
        "U": return 7'h3E;
        "V": return 7'h2A;
        "W": return 7'h7F;
        "X": return 7'h49;
        "Y": return 7'h3B;
        "Z": return 7'h6D;
        "_": return 7'h08;
        default: return 7'h00;   // dot glyph is point-only, so blank here too
      endcase
    endfunction

    // window places past the finished text read as zero (blank)
    function logic [7:0] text_char(input int idx);
      if (idx < text_len && idx < STRING_DEPTH) return text_mem[idx];
      return 8'h00;
    endfunction

    function void note_word(input logic [1:0] c, input logic [7:0] ch, input logic l);
      int         d;
      logic [7:0] seg_bits;
      case (c)
        CMD_LOAD: begin
          // a fresh string drops the old point
          if (load_idx == 0 && !dot_seen) point_pos = NO_POINT;
          if (ch == DOT_CHAR && !dot_seen) begin
            dot_seen  = 1'b1;
            point_pos = load_idx - 1;
          end else if (load_idx < STRING_DEPTH) begin
            text_mem[load_idx] = ch;
            load_idx++;
          end
          if (l) begin
            text_len = load_idx;
            load_idx = 0;
            dot_seen = 1'b0;
          end
        end
        CMD_MUX: begin
          d        = digit_sel % DIGIT_COUNT;
          seg_bits = {1'b0, seg_of(window[d])};
          if (point_pos == int'(scroll_pos) + d) seg_bits[7] = 1'b1;
          drive_seg = seg_bits;
          drive_en  = 4'(1 << d);
          digit_sel = (d + 1) % DIGIT_COUNT;
        end
        CMD_SHIFT: begin
          scroll_pos = scroll_left ? scroll_pos - 8'd1 : scroll_pos + 8'd1;
          if (int'(scroll_pos) >= text_len - DIGIT_COUNT) scroll_left = 1'b1;
          if (scroll_pos == 8'd0) scroll_left = 1'b0;
          for (int i = 0; i < DIGIT_COUNT; i++) window[i] = text_char(int'(scroll_pos) + i);
        end
        default: begin
          scroll_pos  = 8'd1;
          scroll_left = 1'b1;
        end
      endcase
      drive_q.push_back('{en: drive_en, seg: drive_seg});
    endfunction

    function int outstanding();
      return drive_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_word(input logic [3:0] en, input logic [7:0] seg);
      drive_t want;
      if (drive_q.size() == 0) begin
        report($sformatf("unexpected word en=%h seg=%h", en, seg));
      end else begin
        want = drive_q.pop_front();
        if (en !== want.en)
          report($sformatf("digit_enable got %h want %h", en, want.en));
        if (seg !== want.seg)
          report($sformatf("segments got %h want %h", seg, want.seg));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic       last_char;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] digit_enable;
  logic [7:0] segments;

  display_scoreboard sb;
  int words_sent  = 0;
  int cycle_count = 0;
  bit steady_in   = 1'b0;   // sender offers back to back
  bit steady_out  = 1'b0;   // receiver never stalls
  bit long_hold   = 1'b0;   // request for one long receiver hold-off
  bit holding     = 1'b0;   // receiver is in that hold-off

  scrolling_seven_segment_driver uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .char_code    (char_code),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_enable (digit_enable),
    .segments     (segments)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang in either handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any update of that edge
  // lands. The input side is noted first, although a word can never come back
  // in the cycle it went in.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(cmd, char_code, last_char);
      if (out_valid && out_ready) sb.check_word(digit_enable, segments);
    end
  end

  // Offer one word: random gap with valid low, then hold it until taken.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(input logic [1:0] c, input logic [7:0] ch, input logic l);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    char_code <= ch;
    last_char <= l;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Tick or restart: the unused fields still carry random bits.
  task automatic tick(input logic [1:0] c);
    send_word(c, 8'($urandom), 1'($urandom));
  endtask

  task automatic load_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_LOAD, s[i], i == s.len() - 1);
  endtask

  // Text mix: mostly glyphs the table knows, some dots, some raw bytes.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
      2, 3:    return 8'h61 + 8'($urandom_range(0, 25));
      4, 5:    return 8'h30 + 8'($urandom_range(0, 9));
      6:       return $urandom_range(0, 1) ? 8'h2D : 8'h5F;
      7:       return DOT_CHAR;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: random stall before each word, or the one long hold-off when
  // asked. The wait also breaks out on a hold request so it cannot hang on
  // an empty pipe.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        holding   = 1'b1;
        stall     = LONG_HOLD;
      end else begin
        stall = steady_out ? 0 : $urandom_range(0, 12);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      holding = 1'b0;
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !long_hold);
    end
  end

  initial begin
    int  len;
    bit  hold_done;
    bit  drain_done;
    sb         = new();
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_MUX;
    char_code  = 8'h00;
    last_char  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // blank window straight out of reset
    tick(CMD_MUX);
    // leading dot (point at -1, lights nothing), lower case, a second dot
    // kept as a character, bytes outside the table, top byte ends the string
    load_string(".Ab8.z");
    send_word(CMD_LOAD, 8'h7E, 1'b0);
    send_word(CMD_LOAD, 8'hFF, 1'b1);
    tick(CMD_SHIFT);
    repeat (4) tick(CMD_MUX);
    // restart then bounce off position zero
    tick(CMD_RESTART);
    tick(CMD_SHIFT);
    tick(CMD_MUX);
    // short text with the point on the first character
    load_string("1.2");
    tick(CMD_SHIFT);
    tick(CMD_SHIFT);
    tick(CMD_MUX);
    tick(CMD_MUX);

    // --- random ---
    while (words_sent < WORD_TARGET) begin
      if (!hold_done && words_sent >= 150) begin
        // stall the receiver, then push words until in_ready drops
        hold_done = 1'b1;
        long_hold = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (!holding) @(posedge clk);
        steady_in = 1'b1;
        repeat (20) tick(2'($urandom_range(1, 3)));
      end
      if (!drain_done && words_sent >= 300) begin
        // sender goes quiet until every word is back
        drain_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      steady_in  = ($urandom_range(0, 4) == 0);
      steady_out = steady_in;
      if ($urandom_range(0, 9) < 7) begin
        // well-formed: one whole string, sometimes past the store depth,
        // then a run of ticks to scroll and multiplex it
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_word(CMD_LOAD, pick_char(), i == len - 1);
        repeat ($urandom_range(4, 20)) begin
          case ($urandom_range(0, 15))
            0:       tick(CMD_RESTART);
            1, 2, 3, 4, 5, 6: tick(CMD_SHIFT);
            default: tick(CMD_MUX);
          endcase
        end
      end else begin
        // noise: anything at all, including strings cut short
        repeat ($urandom_range(1, 6)) send_word(2'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;

    // --- wind down ---
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
